// ----- rtl/glmt_pkg.sv -----
// glmt_pkg: shared types and constants for the greedy longest-match tokenizer
// used by glmt_vocab_mem and greedy_longest_match_tokenizer; no dependencies
package glmt_pkg;

	localparam int VOCAB_ENTRIES_DEF   = 4096;
	localparam int MAX_ENTRY_BYTES_DEF = 32;
	localparam logic [11:0] BYTE_TOKEN_BASE = 12'd3;
	localparam logic [11:0] BOS_RESET       = 12'd2;

	localparam logic [3:0] CFG_VOCAB_COUNT = 4'd0;
	localparam logic [3:0] CFG_BOS_TOKEN   = 4'd1;

	typedef enum logic [1:0] {
		MODE_ENTRY_BYTE = 2'd0,
		MODE_ENTRY_LEN  = 2'd1,
		MODE_TEXT_BYTE  = 2'd2,
		MODE_END_TEXT   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BOS,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		mode_t       mode;
		logic [11:0] entry_index;
		logic [4:0]  byte_offset;
		logic [7:0]  data_byte;
		logic [5:0]  entry_length;
	} in_word_t;

	typedef struct packed {
		logic [11:0] token_id;
		logic        last_token;
	} out_word_t;

	// vocabulary store write request
	typedef struct packed {
		logic        byte_we;
		logic        len_we;
		logic [11:0] index;
		logic [4:0]  offset;
		logic [7:0]  data;
		logic [5:0]  length;
	} vm_wr_t;

endpackage

// ----- rtl/glmt_vocab_mem.sv -----
// glmt_vocab_mem: vocabulary store, one row of entry bytes and one length per entry
// clears all lengths after reset; depends on glmt_pkg
module glmt_vocab_mem #(
	parameter int VOCAB_ENTRIES   = glmt_pkg::VOCAB_ENTRIES_DEF,
	parameter int MAX_ENTRY_BYTES = glmt_pkg::MAX_ENTRY_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  glmt_pkg::vm_wr_t                wr,
	input  logic [$clog2(VOCAB_ENTRIES)-1:0] raddr,
	output logic [MAX_ENTRY_BYTES*8-1:0]    rd_row_s1,
	output logic [5:0]                      rd_len_s1,
	output logic                            clearing
);
	localparam int IW = $clog2(VOCAB_ENTRIES);
	localparam int OW = $clog2(MAX_ENTRY_BYTES);
	localparam int RW = MAX_ENTRY_BYTES * 8;

	logic [RW-1:0] row_mem [VOCAB_ENTRIES];
	logic [5:0]    len_mem [VOCAB_ENTRIES];
	logic          clearing_q;
	logic [IW-1:0] clr_q;
	logic [31:0]   idx32;
	logic [31:0]   off32;
	logic [IW-1:0] waddr;
	logic [OW-1:0] woff;

	assign idx32    = 32'(wr.index);
	assign off32    = 32'(wr.offset);
	assign waddr    = idx32[IW-1:0];
	assign woff     = off32[OW-1:0];
	assign clearing = clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + IW'(1);
			if (clr_q == IW'(VOCAB_ENTRIES - 1))
				clearing_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q)
			len_mem[clr_q] <= '0;
		else if (wr.len_we)
			len_mem[waddr] <= wr.length;
		if (wr.byte_we)
			row_mem[waddr][{woff, 3'b000} +: 8] <= wr.data;
		rd_len_s1 <= len_mem[raddr];
		rd_row_s1 <= row_mem[raddr];
	end

endmodule

// ----- rtl/greedy_longest_match_tokenizer.sv -----
// greedy_longest_match_tokenizer: load, text and end items in, token words out
// after reset the length store is cleared; no word is accepted until the clear has finished
// load words and text bytes that need no decision are taken in ST_IDLE, the begin token via ST_BOS
// a decision scans the active entries one per cycle, then passes through ST_DRAIN and ST_EMIT:
// a text byte that finds the window full forces one, and end of text forces one per token flushed
// depends on glmt_pkg and glmt_vocab_mem
module greedy_longest_match_tokenizer #(
	parameter int VOCAB_ENTRIES   = glmt_pkg::VOCAB_ENTRIES_DEF,
	parameter int MAX_ENTRY_BYTES = glmt_pkg::MAX_ENTRY_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [3:0]           cfg_index,
	input  logic [12:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  glmt_pkg::in_word_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output glmt_pkg::out_word_t  out_data
);
	localparam int IW = $clog2(VOCAB_ENTRIES);
	localparam int LW = $clog2(MAX_ENTRY_BYTES + 1);
	localparam int OW = $clog2(MAX_ENTRY_BYTES);
	localparam int CW = (IW + 1 > 13) ? IW + 1 : 13;
	localparam int RW = MAX_ENTRY_BYTES * 8;

	glmt_pkg::state_t state_q, state_d;

	logic [12:0]   vc_q;
	logic [11:0]   bos_q;
	logic [7:0]    win_q [MAX_ENTRY_BYTES];
	logic [7:0]    win_d [MAX_ENTRY_BYTES];
	logic [LW-1:0] fill_q, fill_d;
	logic          started_q, started_d;
	logic          eot_q;
	logic [7:0]    byte_q;
	logic [IW-1:0] scan_q;
	logic          valid_s1;
	logic [IW-1:0] idx_s1;
	logic [LW-1:0] match_len_q;
	logic [IW-1:0] best_id_q;
	logic          out_valid_q;
	glmt_pkg::out_word_t out_q;

	logic [CW-1:0] n_act;
	logic          in_acc;
	logic          slot_free;
	logic          full;
	logic          scan_start;
	logic          push;
	glmt_pkg::out_word_t push_word;
	logic          shift_en;
	logic          store_en;
	logic [7:0]    store_byte;
	logic [LW-1:0] used;
	logic [LW-1:0] fill_left;
	logic [LW-1:0] store_pos;
	logic [11:0]   best_tok;
	logic [31:0]   best_ext;
	logic          load_ok;
	logic          off_ok;
	logic          match;
	logic          hit;
	logic          clearing;
	glmt_pkg::vm_wr_t vm_wr;
	logic [RW-1:0] rd_row_s1;
	logic [5:0]    rd_len_s1;

	assign n_act = (CW'(vc_q) > CW'(VOCAB_ENTRIES)) ? CW'(VOCAB_ENTRIES) : CW'(vc_q);
	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != glmt_pkg::ST_IDLE);
	assign slot_free = !out_valid_q || !out_stall;
	assign full      = (fill_q == LW'(MAX_ENTRY_BYTES));
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign used      = (match_len_q == '0) ? LW'(1) : match_len_q;
	assign fill_left = fill_q - used;
	assign best_ext  = 32'(best_id_q);
	assign best_tok  = (match_len_q == '0) ? (12'(win_q[0]) + glmt_pkg::BYTE_TOKEN_BASE)
		: best_ext[11:0];

	// vocabulary writes
	assign load_ok = (32'(in_data.entry_index) < 32'(VOCAB_ENTRIES));
	assign off_ok  = (32'(in_data.byte_offset) < 32'(MAX_ENTRY_BYTES));
	always_comb begin
		vm_wr.byte_we = in_acc && in_data.mode == glmt_pkg::MODE_ENTRY_BYTE && load_ok && off_ok;
		vm_wr.len_we  = in_acc && in_data.mode == glmt_pkg::MODE_ENTRY_LEN && load_ok;
		vm_wr.index   = in_data.entry_index;
		vm_wr.offset  = in_data.byte_offset;
		vm_wr.data    = in_data.data_byte;
		vm_wr.length  = in_data.entry_length;
	end

	glmt_vocab_mem #(
		.VOCAB_ENTRIES  (VOCAB_ENTRIES),
		.MAX_ENTRY_BYTES(MAX_ENTRY_BYTES)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (vm_wr),
		.raddr    (scan_q),
		.rd_row_s1(rd_row_s1),
		.rd_len_s1(rd_len_s1),
		.clearing (clearing)
	);

	// compare stage: entry read last cycle against the window head
	always_comb begin
		match = 1'b1;
		for (int b = 0; b < MAX_ENTRY_BYTES; b++) begin
			if (32'(b) < 32'(rd_len_s1) && rd_row_s1[b*8 +: 8] != win_q[b])
				match = 1'b0;
		end
		hit = valid_s1 && rd_len_s1 != '0
			&& 32'(rd_len_s1) <= 32'(MAX_ENTRY_BYTES)
			&& 32'(rd_len_s1) > 32'(match_len_q)
			&& 32'(rd_len_s1) <= 32'(fill_q)
			&& match;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			glmt_pkg::ST_CLEAR: begin
				if (!clearing)
					state_d = glmt_pkg::ST_IDLE;
			end
			glmt_pkg::ST_IDLE: begin
				if (in_acc && n_act != '0) begin
					if (in_data.mode == glmt_pkg::MODE_TEXT_BYTE) begin
						if (!started_q)
							state_d = glmt_pkg::ST_BOS;
						else if (full)
							state_d = glmt_pkg::ST_SCAN;
					end else if (in_data.mode == glmt_pkg::MODE_END_TEXT) begin
						state_d = started_q ? glmt_pkg::ST_SCAN : glmt_pkg::ST_BOS;
					end
				end
			end
			glmt_pkg::ST_BOS: begin
				if (slot_free)
					state_d = (!eot_q && full) ? glmt_pkg::ST_SCAN : glmt_pkg::ST_IDLE;
			end
			glmt_pkg::ST_SCAN: begin
				if (CW'(scan_q) == n_act - CW'(1))
					state_d = glmt_pkg::ST_DRAIN;
			end
			glmt_pkg::ST_DRAIN: begin
				state_d = glmt_pkg::ST_EMIT;
			end
			glmt_pkg::ST_EMIT: begin
				if (slot_free)
					state_d = (eot_q && fill_left != '0) ? glmt_pkg::ST_SCAN : glmt_pkg::ST_IDLE;
			end
			default: state_d = glmt_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		push      = 1'b0;
		push_word = '0;
		shift_en  = 1'b0;
		store_en  = 1'b0;
		fill_d    = fill_q;
		started_d = started_q;
		unique case (state_q)
			glmt_pkg::ST_IDLE: begin
				if (in_acc && in_data.mode == glmt_pkg::MODE_TEXT_BYTE && n_act != '0
					&& started_q && !full) begin
					store_en = 1'b1;
					fill_d   = fill_q + LW'(1);
				end
				if (in_acc && in_data.mode == glmt_pkg::MODE_END_TEXT && n_act == '0) begin
					fill_d    = '0;
					started_d = 1'b0;
				end
			end
			glmt_pkg::ST_BOS: begin
				if (slot_free) begin
					push                 = 1'b1;
					push_word.token_id   = bos_q;
					push_word.last_token = eot_q;
					if (eot_q) begin
						fill_d    = '0;
						started_d = 1'b0;
					end else begin
						started_d = 1'b1;
						if (!full) begin
							store_en = 1'b1;
							fill_d   = fill_q + LW'(1);
						end
					end
				end
			end
			glmt_pkg::ST_EMIT: begin
				if (slot_free) begin
					push                 = 1'b1;
					push_word.token_id   = best_tok;
					push_word.last_token = eot_q && fill_left == '0;
					shift_en             = 1'b1;
					fill_d               = fill_left;
					if (eot_q) begin
						if (fill_left == '0)
							started_d = 1'b0;
					end else begin
						store_en = 1'b1;
						fill_d   = fill_left + LW'(1);
					end
				end
			end
			default: ;
		endcase
	end

	assign scan_start = (state_d == glmt_pkg::ST_SCAN) && (state_q != glmt_pkg::ST_SCAN);
	assign store_pos  = shift_en ? fill_left : fill_q;
	// in the idle state a pending text byte is taken from the input directly
	assign store_byte = (state_q == glmt_pkg::ST_IDLE) ? in_data.data_byte : byte_q;

	// window update: drop consumed bytes, then append the pending text byte
	always_comb begin
		for (int b = 0; b < MAX_ENTRY_BYTES; b++) begin
			win_d[b] = win_q[b];
			if (shift_en && 32'(b) + 32'(used) < 32'(MAX_ENTRY_BYTES))
				win_d[b] = win_q[OW'(32'(b) + 32'(used))];
			if (store_en && LW'(b) == store_pos)
				win_d[b] = store_byte;
		end
	end

	always_ff @(posedge clk) begin
		for (int b = 0; b < MAX_ENTRY_BYTES; b++)
			win_q[b] <= win_d[b];
		if (in_acc)
			byte_q <= in_data.data_byte;
		idx_s1 <= scan_q;
		if (push)
			out_q <= push_word;
		if (scan_start) begin
			match_len_q <= '0;
			best_id_q   <= '0;
		end else if (hit) begin
			match_len_q <= LW'(rd_len_s1);
			best_id_q   <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= glmt_pkg::ST_CLEAR;
			vc_q        <= '0;
			bos_q       <= glmt_pkg::BOS_RESET;
			fill_q      <= '0;
			started_q   <= 1'b0;
			eot_q       <= 1'b0;
			scan_q      <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			fill_q    <= fill_d;
			started_q <= started_d;
			valid_s1  <= (state_q == glmt_pkg::ST_SCAN);
			if (cfg_we && cfg_index == glmt_pkg::CFG_VOCAB_COUNT)
				vc_q <= cfg_data;
			if (cfg_we && cfg_index == glmt_pkg::CFG_BOS_TOKEN)
				bos_q <= cfg_data[11:0];
			if (in_acc)
				eot_q <= (in_data.mode == glmt_pkg::MODE_END_TEXT);
			if (scan_start)
				scan_q <= '0;
			else if (state_q == glmt_pkg::ST_SCAN)
				scan_q <= scan_q + IW'(1);
			if (push)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule
